/* rtl/core/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, codes and constants of the pausable timer bank: item
// structures, opcodes, timer phase codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // default bank size
  localparam int NUM_TIMERS_DEF = 8;

  // widths fixed by the item formats
  localparam int OPC_W   = 3;
  localparam int TIDX_W  = 3;
  localparam int TIME_W  = 32;
  localparam int PHASE_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MASK_W  = 8;

  // opcodes
  localparam logic [OPC_W-1:0] OP_RUN    = 3'd0;
  localparam logic [OPC_W-1:0] OP_START  = 3'd1;
  localparam logic [OPC_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OPC_W-1:0] OP_PERIOD = 3'd3;
  localparam logic [OPC_W-1:0] OP_PAUSE  = 3'd4;

  // timer phases
  localparam logic [PHASE_W-1:0] PH_STOPPING = 4'd0;
  localparam logic [PHASE_W-1:0] PH_STOPPED  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_STARTING = 4'd2;
  localparam logic [PHASE_W-1:0] PH_STARTED  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_PAUSING  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_PAUSED   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_RESUME   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_EXPIRING = 4'd7;
  localparam logic [PHASE_W-1:0] PH_EXPIRED  = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LIMIT   = 2'd1;

  // input item
  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [TIDX_W-1:0] timer_index;
    logic [TIME_W-1:0] value;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [TIDX_W-1:0] expired_timer;
    logic              last_in_pass;
  } out_item_t;

  // one row of the timer table
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] saved_phase;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  pause_time;
    logic [TIME_W-1:0]  period_ms;
  } timer_row_t;

  // command context handed to the step unit
  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic              pause_new;
    logic [TIME_W-1:0] value;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] pause_limit;
  } step_cmd_t;

  // step unit outcome
  typedef struct packed {
    logic wr_en;
    logic expired;
  } step_res_t;

endpackage

/* rtl/core/ptb_timer_step.sv */
// ----------------------------------------------------------------------------
// ptb_timer_step
// Shared per-timer update unit: takes one row of the timer table and the
// current command and gives the new row, a write enable and the expiry flag.
// ----------------------------------------------------------------------------
module ptb_timer_step (
  input  ptb_pkg::step_cmd_t  cmd,
  input  ptb_pkg::timer_row_t row_in,
  input  logic                pausable,
  output ptb_pkg::timer_row_t row_out,
  output ptb_pkg::step_res_t  res
);

  logic [ptb_pkg::TIME_W-1:0] run_elapsed;
  logic [ptb_pkg::TIME_W-1:0] pause_elapsed;

  // elapsed times, modulo 2^32
  assign run_elapsed   = cmd.now_ms - row_in.start_time;
  assign pause_elapsed = cmd.now_ms - row_in.pause_time;

  // transition of one timer
  always_comb begin
    row_out     = row_in;
    res.wr_en   = 1'b0;
    res.expired = 1'b0;
    case (cmd.opcode)
      ptb_pkg::OP_RUN: begin
        unique case (row_in.phase)
          ptb_pkg::PH_STOPPING: begin
            row_out.phase = ptb_pkg::PH_STOPPED;
            res.wr_en     = 1'b1;
          end
          ptb_pkg::PH_STARTING: begin
            row_out.start_time = cmd.now_ms;
            row_out.phase      = ptb_pkg::PH_STARTED;
            res.wr_en          = 1'b1;
          end
          ptb_pkg::PH_STARTED: begin
            if (run_elapsed > row_in.period_ms) begin
              row_out.phase = ptb_pkg::PH_EXPIRING;
              res.wr_en     = 1'b1;
            end
          end
          ptb_pkg::PH_PAUSING: begin
            row_out.pause_time = cmd.now_ms;
            row_out.phase      = ptb_pkg::PH_PAUSED;
            res.wr_en          = 1'b1;
          end
          ptb_pkg::PH_PAUSED: begin
            // auto-resume once the pause has outlasted the limit
            if ((cmd.pause_limit != '0) && pausable && (pause_elapsed > cmd.pause_limit)) begin
              row_out.phase = ptb_pkg::PH_RESUME;
              res.wr_en     = 1'b1;
            end
          end
          ptb_pkg::PH_RESUME: begin
            // push the start forward by the length of the pause
            row_out.start_time = row_in.start_time + pause_elapsed;
            row_out.phase      = row_in.saved_phase;
            res.wr_en          = 1'b1;
          end
          ptb_pkg::PH_EXPIRING: begin
            row_out.phase = ptb_pkg::PH_EXPIRED;
            res.wr_en     = 1'b1;
          end
          ptb_pkg::PH_EXPIRED: begin
            res.expired = 1'b1;
          end
          default: begin
            row_out = row_in;
          end
        endcase
      end
      ptb_pkg::OP_START: begin
        row_out.phase = ptb_pkg::PH_STARTING;
        res.wr_en     = 1'b1;
      end
      ptb_pkg::OP_STOP: begin
        row_out.phase = ptb_pkg::PH_STOPPING;
        res.wr_en     = 1'b1;
      end
      ptb_pkg::OP_PERIOD: begin
        row_out.period_ms = cmd.value;
        res.wr_en         = 1'b1;
      end
      ptb_pkg::OP_PAUSE: begin
        // only pausable timers follow a pause toggle
        if (pausable) begin
          if (cmd.pause_new) begin
            row_out.saved_phase = row_in.phase;
            row_out.phase       = ptb_pkg::PH_PAUSING;
          end else begin
            row_out.phase = ptb_pkg::PH_RESUME;
          end
          res.wr_en = 1'b1;
        end
      end
      default: begin
        row_out = row_in;
      end
    endcase
  end

endmodule

/* rtl/core/pausable_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// pausable_timer_bank_unit
// Bank of millisecond timers with a global pause. Timer rows sit in a table
// that a small sequencer walks one row per cycle through a shared step unit.
// ----------------------------------------------------------------------------
//  channel  | ports                         | flow
//  ---------+-------------------------------+------------------------------
//  command  | start, busy, in_item          | taken when start & !busy
//  result   | out_valid, out_item           | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_wdata  | written on any edge with cfg_we
//
//  A run pass walks every row, then drains and flushes; a pause toggle
//  walks every row and drains; start, stop and set-period visit one row.
//  The walk is paced by the single read port of the timer table: one row
//  enters the step unit each cycle. Items that change nothing leave busy low.
//  Expiry results appear during the walk; the last of a pass comes in the
//  first cycle after busy falls. Synchronous reset clears all timer rows.
// ----------------------------------------------------------------------------
module pausable_timer_bank_unit #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ptb_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  output ptb_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int XW = (IW > ptb_pkg::TIDX_W) ? IW : ptb_pkg::TIDX_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [IW-1:0]                     cnt_r;
  logic [IW-1:0]                     hi_r;
  logic [ptb_pkg::OPC_W-1:0]         op_r;
  logic                              pause_new_r;
  logic [ptb_pkg::TIME_W-1:0]        value_r;
  logic [ptb_pkg::TIME_W-1:0]        now_r;
  logic                              pause_on_r;
  logic [ptb_pkg::MASK_W-1:0]        mask_r;
  logic [ptb_pkg::TIME_W-1:0]        limit_r;

  ptb_pkg::timer_row_t               mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]             row_vld_r;
  ptb_pkg::timer_row_t               rd_row_r;
  logic                              rd_vld_r;
  logic                              eval_vld_r;
  logic [IW-1:0]                     eval_idx_r;
  logic [XW-1:0]                     eval_idx_ext;

  logic                              pend_vld_r;
  logic [ptb_pkg::TIDX_W-1:0]        pend_idx_r;
  logic                              out_valid_r;
  ptb_pkg::out_item_t                out_item_r;

  logic                              accept;
  logic                              single_op;
  logic                              idx_ok;
  logic                              pause_on_in;
  logic                              do_walk;
  logic                              do_single;
  ptb_pkg::timer_row_t               row_cur;
  ptb_pkg::timer_row_t               row_new;
  ptb_pkg::step_cmd_t                step_cmd;
  ptb_pkg::step_res_t                step_res;
  logic                              pausable;
  logic                              wr_en;
  logic                              hit;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // decode of the incoming item
  assign single_op = (in_item.opcode == ptb_pkg::OP_START) ||
                     (in_item.opcode == ptb_pkg::OP_STOP)  ||
                     (in_item.opcode == ptb_pkg::OP_PERIOD);
  assign idx_ok      = (32'(in_item.timer_index) < NUM_TIMERS);
  assign pause_on_in = (in_item.value != '0);
  assign do_single   = accept && single_op && idx_ok;
  assign do_walk     = accept && ((in_item.opcode == ptb_pkg::OP_RUN) ||
                       ((in_item.opcode == ptb_pkg::OP_PAUSE) && (pause_on_in != pause_on_r)));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptb_pkg::CFG_PAUSABLE_MASK: mask_r  <= cfg_wdata[ptb_pkg::MASK_W-1:0];
        ptb_pkg::CFG_PAUSE_LIMIT:   limit_r <= cfg_wdata[ptb_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (do_walk || do_single) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == hi_r) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = (op_r == ptb_pkg::OP_RUN) ? ST_FLUSH : ST_IDLE;
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pause_on_r <= 1'b0;
      eval_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      eval_vld_r <= (state_r == ST_SCAN);
      if (do_walk && (in_item.opcode == ptb_pkg::OP_PAUSE)) begin
        pause_on_r <= pause_on_in;
      end
    end
  end

  // item latch and walk counter
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_item.opcode;
      pause_new_r <= pause_on_in;
      value_r     <= in_item.value;
      now_r       <= in_item.now_ms;
      if (single_op) begin
        cnt_r <= IW'(in_item.timer_index);
        hi_r  <= IW'(in_item.timer_index);
      end else begin
        cnt_r <= '0;
        hi_r  <= IW'(NUM_TIMERS - 1);
      end
    end else if (state_r == ST_SCAN) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == ST_SCAN) begin
      eval_idx_r <= cnt_r;
    end
  end

  // timer table: one registered read and one write per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      rd_row_r <= mem[cnt_r];
    end
    if (wr_en) begin
      mem[eval_idx_r] <= row_new;
    end
  end

  // row valid bits; an unwritten row reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (state_r == ST_SCAN) begin
        rd_vld_r <= row_vld_r[cnt_r];
      end
      if (wr_en) begin
        row_vld_r[eval_idx_r] <= 1'b1;
      end
    end
  end

  assign row_cur      = rd_vld_r ? rd_row_r : '0;
  assign eval_idx_ext = XW'(eval_idx_r);
  assign pausable     = ((eval_idx_ext >> ptb_pkg::TIDX_W) == '0) &&
                        mask_r[eval_idx_ext[ptb_pkg::TIDX_W-1:0]];

  assign step_cmd.opcode      = op_r;
  assign step_cmd.pause_new   = pause_new_r;
  assign step_cmd.value       = value_r;
  assign step_cmd.now_ms      = now_r;
  assign step_cmd.pause_limit = limit_r;

  // shared step unit
  ptb_timer_step u_step (
    .cmd     (step_cmd),
    .row_in  (row_cur),
    .pausable(pausable),
    .row_out (row_new),
    .res     (step_res)
  );

  assign wr_en = eval_vld_r && step_res.wr_en;
  assign hit   = eval_vld_r && step_res.expired;

  // result output: hold one expiry back so the last of a pass can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (hit) begin
        pend_vld_r <= 1'b1;
        if (pend_vld_r) begin
          out_valid_r <= 1'b1;
        end
      end else if ((state_r == ST_FLUSH) && pend_vld_r) begin
        pend_vld_r  <= 1'b0;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pend_idx_r                <= eval_idx_ext[ptb_pkg::TIDX_W-1:0];
      out_item_r.expired_timer  <= pend_idx_r;
      out_item_r.last_in_pass   <= 1'b0;
    end else if (state_r == ST_FLUSH) begin
      out_item_r.expired_timer  <= pend_idx_r;
      out_item_r.last_in_pass   <= 1'b1;
    end
  end

  // checks
  a_eval_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !eval_vld_r)
    else $error("row evaluated while the sequencer is idle");

  a_pend_only_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (op_r == ptb_pkg::OP_RUN))
    else $error("expiry held back outside a run pass");

  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_in_pass) |=> !out_valid)
    else $error("result straight after the last of a pass");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> !pend_vld_r)
    else $error("held expiry survived the end of a pass");

  a_wr_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == ST_SCAN) || (state_r == ST_DRAIN)))
    else $error("timer row written outside a walk");

endmodule
